### hdl/fsmf_pkg.sv
// Package for the first substring match finder.
// Holds sizes, configuration register indexes, item and config types, and byte helpers.
// No dependencies.
package fsmf_pkg;

  // Block sizes
  localparam int unsigned MAX_NEEDLE  = 16;
  localparam int unsigned OFFSET_BITS = 32;
  localparam int unsigned LEN_BITS    = $clog2(MAX_NEEDLE + 1);
  localparam int unsigned NIDX_BITS   = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
  localparam int unsigned START_BITS  = 32;

  // Item queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Configuration port
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 64;
  localparam int unsigned RAW_LEN_BITS  = 5;

  localparam logic [CFG_IDX_BITS-1:0] REG_NEEDLE_LOW  = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_NEEDLE_HIGH = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_NEEDLE_LEN  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_CASE_FOLD   = 3'd3;

  // One haystack byte as it travels through the queue (stored unfolded)
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  // Match settings seen by the back end
  typedef struct packed {
    logic [MAX_NEEDLE-1:0][7:0] needle;
    logic [LEN_BITS-1:0]        len;
    logic                       fold;
  } cfg_t;

  // Lower ASCII A-Z when folding is on
  function automatic logic [7:0] fold_byte(input logic [7:0] b, input logic en);
    logic [7:0] r;
    r = b;
    if (en && (b >= 8'h41) && (b <= 8'h5A)) begin
      r = b + 8'd32;
    end
    return r;
  endfunction

  // Clamp the raw length register to 1..MAX_NEEDLE
  function automatic logic [LEN_BITS-1:0] eff_len(input logic [RAW_LEN_BITS-1:0] raw);
    logic [LEN_BITS-1:0] r;
    if (raw == '0) begin
      r = LEN_BITS'(1);
    end else if (32'(raw) > MAX_NEEDLE) begin
      r = LEN_BITS'(MAX_NEEDLE);
    end else begin
      r = LEN_BITS'(raw);
    end
    return r;
  endfunction

endpackage

### hdl/first_substring_match_finder.sv
// Top level of the first substring match finder: config registers, front end, queue, back end.
// Depends on fsmf_pkg, fsmf_queue and fsmf_back.
//
// Usage:
//   Haystack bytes enter on the input channel (in_valid_i/in_ready_o) with data_byte_i and
//   last_byte_i. One result (found_o, match_start_o) leaves on the output channel
//   (out_valid_o/out_ready_i) for each byte marked last; other bytes give no result.
//   The needle, its length and the case-fold flag are set through the write port
//   (cfg_we_i, cfg_idx_i, cfg_data_i); the user must do so only while no haystack is in
//   flight, since nothing in the block enforces it.
//   Throughput: one byte per cycle while the result register is not stalled; the back end
//   pops one queued item per cycle and compares all needle positions in that same cycle.
//   Order: the queue is written when a byte is accepted; the compare and the result
//   register load happen when the back end pops it, which waits while a result is held.
//   Receiver stall: the result waits in its register; the back end stops popping and the
//   two-entry queue fills, after which in_ready_o drops. No item is lost.
//   Reset: clears the queue, window, counters and result valid flag; needle reads zero,
//   length one, case fold off.
module first_substring_match_finder
  import fsmf_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               data_byte_i,
  input  logic                     last_byte_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic                     found_o,
  output logic [START_BITS-1:0]    match_start_o,
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  logic [63:0]             needle_low_q, needle_high_q;
  logic [RAW_LEN_BITS-1:0] needle_len_q;
  logic                    case_fold_q;
  logic [127:0]            needle_all;
  cfg_t                    cfg;
  item_t                   push_item, head_item;
  logic                    push, q_full, q_valid, pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_low_q  <= '0;
      needle_high_q <= '0;
      needle_len_q  <= RAW_LEN_BITS'(1);
      case_fold_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_NEEDLE_LOW:  needle_low_q  <= cfg_data_i[63:0];
        REG_NEEDLE_HIGH: needle_high_q <= cfg_data_i[63:0];
        REG_NEEDLE_LEN:  needle_len_q  <= cfg_data_i[RAW_LEN_BITS-1:0];
        REG_CASE_FOLD:   case_fold_q   <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // needle bytes, clamped length and fold flag for the back end
  assign needle_all = {needle_high_q, needle_low_q};
  always_comb begin
    for (int i = 0; i < MAX_NEEDLE; i++) begin
      cfg.needle[i] = (i < 16) ? needle_all[(8*(i % 16))+:8] : 8'h00;
    end
    cfg.len  = eff_len(needle_len_q);
    cfg.fold = case_fold_q;
  end

  // front end: accept the byte as is and queue it
  assign in_ready_o     = !q_full;
  assign push           = in_valid_i && !q_full;
  assign push_item.data = data_byte_i;
  assign push_item.last = last_byte_i;

  fsmf_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (head_item)
  );

  fsmf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .item_valid_i  (q_valid),
    .item_i        (head_item),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .match_start_o (match_start_o)
  );

endmodule

### hdl/fsmf_queue.sv
// Small item queue that decouples the front end from the match back end.
// Depends on fsmf_pkg (item_t, QUEUE_DEPTH).
module fsmf_queue
  import fsmf_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t push_item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t head_o
);

  item_t                mem_q [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_BITS-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_BITS'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_BITS'(1);
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - QCNT_BITS'(1);
    end
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= (32'(wr_ptr_q) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_q + QPTR_BITS'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (32'(rd_ptr_q) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_q + QPTR_BITS'(1);
      end
    end
  end

  // payload storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

### hdl/fsmf_back.sv
// Match back end: byte window, needle compare, first-match tracking, result register.
// Depends on fsmf_pkg (item_t, cfg_t, sizes).
module fsmf_back
  import fsmf_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cfg_t                  cfg_i,
  input  logic                  item_valid_i,
  input  item_t                 item_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  found_o,
  output logic [START_BITS-1:0] match_start_o
);

  logic [MAX_NEEDLE-1:0][7:0] win_q, win_d;
  logic [OFFSET_BITS-1:0]     cnt_q, cnt_d;
  logic [OFFSET_BITS-1:0]     off_q, off_d, off_cand;
  logic                       seen_q, seen_d;
  logic [MAX_NEEDLE-1:0]      byte_ok;
  logic                       hit;
  logic                       out_valid_q;
  logic                       found_q;
  logic [START_BITS-1:0]      start_q;

  // take the next item when the result slot is free or being drained
  assign pop_o = item_valid_i && (!out_valid_q || out_ready_i);

  // shifted window, newest byte at position 0
  always_comb begin
    win_d[0] = item_i.data;
    for (int k = 1; k < MAX_NEEDLE; k++) begin
      win_d[k] = win_q[k-1];
    end
  end

  // saturating byte count
  assign cnt_d = (&cnt_q) ? cnt_q : cnt_q + OFFSET_BITS'(1);

  // per-position compare: age k holds needle byte len-1-k; folding uses the current flag
  always_comb begin
    logic [LEN_BITS-1:0] idx;
    for (int k = 0; k < MAX_NEEDLE; k++) begin
      idx        = cfg_i.len - LEN_BITS'(1) - LEN_BITS'(k);
      byte_ok[k] = (LEN_BITS'(k) >= cfg_i.len) ||
                   (fold_byte(win_d[k], cfg_i.fold) == cfg_i.needle[idx[NIDX_BITS-1:0]]);
    end
  end

  assign hit      = (&byte_ok) && (cnt_d >= OFFSET_BITS'(cfg_i.len));
  assign off_cand = cnt_d - OFFSET_BITS'(cfg_i.len);

  // first match bookkeeping
  always_comb begin
    seen_d = seen_q;
    off_d  = off_q;
    if (!seen_q && hit) begin
      seen_d = 1'b1;
      off_d  = off_cand;
    end
  end

  // haystack state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      cnt_q  <= '0;
      seen_q <= 1'b0;
      off_q  <= '0;
    end else if (pop_o) begin
      if (item_i.last) begin
        win_q  <= '0;
        cnt_q  <= '0;
        seen_q <= 1'b0;
        off_q  <= '0;
      end else begin
        win_q  <= win_d;
        cnt_q  <= cnt_d;
        seen_q <= seen_d;
        off_q  <= off_d;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pop_o && item_i.last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && item_i.last) begin
      found_q <= seen_d;
      start_q <= seen_d ? START_BITS'(off_d) : '0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign match_start_o = start_q;

endmodule

### sim/tb_top.sv
// Testbench for first_substring_match_finder: a directed table, then random haystacks
// checked against a scoreboard that models the search. Depends on fsmf_pkg and the RTL.
module tb_top;
  import fsmf_pkg::*;

  localparam int unsigned CLK_PERIOD     = 8;
  localparam int unsigned RESET_CYCLES   = 6;
  localparam int unsigned SETTLE_CYCLES  = 8;    // queue + compare + result register, plus margin
  localparam int unsigned HOLD_CYCLES    = 100;  // receiver hold-off for the back-pressure phase
  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned RAND_ITEMS     = 400;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic                  found;
    logic [START_BITS-1:0] start;
  } hit_report_t;

  typedef enum logic [1:0] {
    ROW_CFG,      // register write, after the block has drained
    ROW_BYTE,     // byte checked against the scoreboard model
    ROW_CHECKED   // last byte with its result typed in below
  } row_kind_e;

  typedef struct packed {
    row_kind_e                kind;
    logic [CFG_IDX_BITS-1:0]  reg_idx;
    logic [CFG_DATA_BITS-1:0] reg_val;
    logic [7:0]               data;
    logic                     last;
    logic                     found;
    logic [START_BITS-1:0]    start;
  } stim_row_t;

  localparam int unsigned DIR_ROWS = 30;

  // Directed table: extremes, short haystack, case fold, clamped lengths,
  // a length change between two bytes of one haystack, an unused register index
  stim_row_t dir_tab [DIR_ROWS] = '{
    '{ROW_CHECKED, REG_NEEDLE_LOW,  64'd0,        8'h00, 1'b1, 1'b1, 32'd0}, // reset needle 00
    '{ROW_CHECKED, REG_NEEDLE_LOW,  64'd0,        8'hFF, 1'b1, 1'b0, 32'd0},
    '{ROW_CFG,     REG_NEEDLE_LOW,  64'h636261,   8'h00, 1'b0, 1'b0, 32'd0}, // "abc"
    '{ROW_CFG,     REG_NEEDLE_LEN,  64'd3,        8'h00, 1'b0, 1'b0, 32'd0},
    '{ROW_BYTE,    REG_NEEDLE_LOW,  64'd0,        8'h78, 1'b0, 1'b0, 32'd0}, // x
    '{ROW_BYTE,    REG_NEEDLE_LOW,  64'd0,        8'h61, 1'b0, 1'b0, 32'd0},
    '{ROW_BYTE,    REG_NEEDLE_LOW,  64'd0,        8'h62, 1'b0, 1'b0, 32'd0},
    '{ROW_CHECKED, REG_NEEDLE_LOW,  64'd0,        8'h63, 1'b1, 1'b1, 32'd1},
    '{ROW_BYTE,    REG_NEEDLE_LOW,  64'd0,        8'h61, 1'b0, 1'b0, 32'd0}, // too short
    '{ROW_CHECKED, REG_NEEDLE_LOW,  64'd0,        8'h62, 1'b1, 1'b0, 32'd0},
    '{ROW_CFG,     REG_CASE_FOLD,   64'd1,        8'h00, 1'b0, 1'b0, 32'd0},
    '{ROW_BYTE,    REG_NEEDLE_LOW,  64'd0,        8'h41, 1'b0, 1'b0, 32'd0}, // "ABC" folds
    '{ROW_BYTE,    REG_NEEDLE_LOW,  64'd0,        8'h42, 1'b0, 1'b0, 32'd0},
    '{ROW_CHECKED, REG_NEEDLE_LOW,  64'd0,        8'h43, 1'b1, 1'b1, 32'd0},
    '{ROW_CFG,     REG_NEEDLE_LOW,  64'h41,       8'h00, 1'b0, 1'b0, 32'd0}, // upper 'A'
    '{ROW_CFG,     REG_NEEDLE_LEN,  64'd0,        8'h00, 1'b0, 1'b0, 32'd0}, // zero acts as one
    '{ROW_CHECKED, REG_NEEDLE_LOW,  64'd0,        8'h41, 1'b1, 1'b0, 32'd0},
    '{ROW_CFG,     REG_CASE_FOLD,   64'd0,        8'h00, 1'b0, 1'b0, 32'd0},
    '{ROW_CHECKED, REG_NEEDLE_LOW,  64'd0,        8'h41, 1'b1, 1'b1, 32'd0},
    '{ROW_CFG,     REG_NEEDLE_LOW,  64'h6261,     8'h00, 1'b0, 1'b0, 32'd0}, // "ab"
    '{ROW_CFG,     REG_NEEDLE_LEN,  64'd1,        8'h00, 1'b0, 1'b0, 32'd0},
    '{ROW_BYTE,    REG_NEEDLE_LOW,  64'd0,        8'h78, 1'b0, 1'b0, 32'd0},
    '{ROW_CFG,     REG_NEEDLE_LEN,  64'd2,        8'h00, 1'b0, 1'b0, 32'd0}, // mid-haystack
    '{ROW_BYTE,    REG_NEEDLE_LOW,  64'd0,        8'h61, 1'b0, 1'b0, 32'd0},
    '{ROW_BYTE,    REG_NEEDLE_LOW,  64'd0,        8'h62, 1'b1, 1'b0, 32'd0},
    '{ROW_CFG,     REG_NEEDLE_HIGH, '1,           8'h00, 1'b0, 1'b0, 32'd0},
    '{ROW_CFG,     REG_NEEDLE_LEN,  64'd31,       8'h00, 1'b0, 1'b0, 32'd0}, // clamps to 16
    '{ROW_CFG,     REG_UNUSED,      '1,           8'h00, 1'b0, 1'b0, 32'd0},
    '{ROW_BYTE,    REG_NEEDLE_LOW,  64'd0,        8'h71, 1'b1, 1'b0, 32'd0},
    '{ROW_BYTE,    REG_NEEDLE_LOW,  64'd0,        8'h80, 1'b1, 1'b0, 32'd0}
  };

  // DUT signals
  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [7:0]               data_byte_i;
  logic                     last_byte_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic                     found_o;
  logic [START_BITS-1:0]    match_start_o;
  logic                     cfg_we_i;
  logic [CFG_IDX_BITS-1:0]  cfg_idx_i;
  logic [CFG_DATA_BITS-1:0] cfg_data_i;

  // Scoreboard copy of the registers and of the per-haystack state
  logic [63:0]            needle_lo_q;
  logic [63:0]            needle_hi_q;
  logic [RAW_LEN_BITS-1:0] len_raw_q;
  logic                   fold_q;
  logic [7:0]             win_q [MAX_NEEDLE];
  logic [OFFSET_BITS-1:0] seen_cnt_q;
  logic                   hit_q;
  logic [OFFSET_BITS-1:0] first_off_q;

  hit_report_t expected_reports [$];

  int unsigned mismatches;
  int unsigned reports_checked;
  int unsigned bytes_sent;
  int unsigned stacks_sent;
  int unsigned settings_used;
  int unsigned idle_cycles;
  bit          no_gaps;
  logic        hold_req;
  logic        hold_ack;

  first_substring_match_finder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .data_byte_i   (data_byte_i),
    .last_byte_i   (last_byte_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .found_o       (found_o),
    .match_start_o (match_start_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Search model: shift one byte in, compare the newest bytes, report on last
  function automatic bit scan_byte(input logic [7:0] b, input logic l, output hit_report_t rep);
    int unsigned n;
    int unsigned i;
    bit          hit;
    logic [7:0]  h;
    logic [7:0]  nb;
    n = (len_raw_q == '0) ? 1 : ((32'(len_raw_q) > MAX_NEEDLE) ? MAX_NEEDLE : 32'(len_raw_q));
    for (i = 0; i < MAX_NEEDLE - 1; i++) begin
      win_q[i] = win_q[i + 1];
    end
    win_q[MAX_NEEDLE - 1] = b;
    if (seen_cnt_q != '1) begin
      seen_cnt_q = seen_cnt_q + 1'b1;
    end
    if (!hit_q && (seen_cnt_q >= n)) begin
      hit = 1'b1;
      for (i = 0; i < n; i++) begin
        h = win_q[MAX_NEEDLE - n + i];
        if (fold_q && (h >= 8'h41) && (h <= 8'h5A)) begin
          h = h + 8'd32;
        end
        nb = (i < 8) ? needle_lo_q[8 * i +: 8] : needle_hi_q[8 * (i - 8) +: 8];
        if (h != nb) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        hit_q       = 1'b1;
        first_off_q = seen_cnt_q - n;
      end
    end
    rep.found = hit_q;
    rep.start = hit_q ? first_off_q[START_BITS-1:0] : '0;
    if (l) begin
      for (i = 0; i < MAX_NEEDLE; i++) begin
        win_q[i] = '0;
      end
      seen_cnt_q  = '0;
      hit_q       = 1'b0;
      first_off_q = '0;
    end
    return l;
  endfunction

  // Offer one item and hold it until accepted; optional one-cycle gap afterwards
  task automatic push_byte(input logic [7:0] b, input logic l, input bit typed,
                           input hit_report_t typed_rep);
    hit_report_t rep;
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= l;
    do @(posedge clk_i); while (!in_ready_o);
    if (scan_byte(b, l, rep)) begin
      expected_reports.push_back(typed ? typed_rep : rep);
      stacks_sent++;
    end
    bytes_sent++;
    if (!no_gaps && ($urandom_range(99) < 32)) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  // Register write once every result is out and the pipeline is empty
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_NEEDLE_LOW:  needle_lo_q = val;
      REG_NEEDLE_HIGH: needle_hi_q = val;
      REG_NEEDLE_LEN:  len_raw_q   = val[RAW_LEN_BITS-1:0];
      REG_CASE_FOLD:   fold_q      = val[0];
      default: ;
    endcase
  endtask

  task automatic log_mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("tb_top: %s mismatch, expected %0d got %0d", what, want, got);
    end
  endtask

  // Result checker
  always @(posedge clk_i) begin
    hit_report_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      reports_checked++;
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("tb_top: result with nothing pending, found %0d start %0d",
                   found_o, match_start_o);
        end
      end else begin
        want = expected_reports.pop_front();
        if (found_o !== want.found) begin
          log_mismatch("found", 32'(want.found), 32'(found_o));
        end
        if (match_start_o !== want.start) begin
          log_mismatch("match_start", want.start, match_start_o);
        end
      end
    end
  end

  // Watchdog on cycles with no traffic on any port
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: watchdog expired, %0d results outstanding", expected_reports.size());
      $display("tb_top: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request
  initial begin
    out_ready_i = 1'b0;
    hold_ack    = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_req != hold_ack) begin
        hold_ack = hold_req;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        out_ready_i <= no_gaps || ($urandom_range(99) >= 24);
      end
    end
  end

  // Item sender and register writer
  initial begin
    int unsigned row;
    int unsigned phase;
    int unsigned rand_start;
    int unsigned style;
    int unsigned eff;
    int unsigned hay_len;
    int unsigned pos;
    int unsigned nstacks;
    int unsigned k;
    int unsigned i;
    bit          embed;
    logic [4:0]  len_raw;
    logic        fold_on;
    logic [7:0]  b;
    logic [7:0]  needle_b [MAX_NEEDLE];
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] word;
    hit_report_t typed_rep;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    data_byte_i = '0;
    last_byte_i = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = '0;
    cfg_data_i  = '0;
    hold_req    = 1'b0;
    no_gaps     = 1'b0;
    idle_cycles = 0;
    mismatches  = 0;
    reports_checked = 0;
    bytes_sent  = 0;
    stacks_sent = 0;
    settings_used = 0;
    needle_lo_q = '0;
    needle_hi_q = '0;
    len_raw_q   = 5'd1;
    fold_q      = 1'b0;
    for (i = 0; i < MAX_NEEDLE; i++) begin
      win_q[i] = '0;
    end
    seen_cnt_q  = '0;
    hit_q       = 1'b0;
    first_off_q = '0;

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    // Directed table
    for (row = 0; row < DIR_ROWS; row++) begin
      typed_rep.found = dir_tab[row].found;
      typed_rep.start = dir_tab[row].start;
      case (dir_tab[row].kind)
        ROW_CFG: begin
          write_reg(dir_tab[row].reg_idx, dir_tab[row].reg_val);
          settings_used++;
        end
        ROW_CHECKED: push_byte(dir_tab[row].data, dir_tab[row].last, 1'b1, typed_rep);
        default:     push_byte(dir_tab[row].data, dir_tab[row].last, 1'b0, typed_rep);
      endcase
    end

    // Random phases: new needle settings, then a few haystacks each
    rand_start = bytes_sent;
    phase = 0;
    while (bytes_sent - rand_start < RAND_ITEMS) begin
      case (phase)
        0:       len_raw = 5'd16;
        1:       len_raw = 5'd1;
        2:       len_raw = 5'd31;
        3:       len_raw = 5'd0;
        4:       len_raw = 5'd17;
        default: len_raw = ($urandom_range(9) == 0) ? 5'($urandom_range(17, 31))
                                                    : 5'($urandom_range(1, 16));
      endcase
      eff = (len_raw == 0) ? 1 : ((len_raw > MAX_NEEDLE) ? MAX_NEEDLE : len_raw);
      // 0: any byte, 1: all ones, else a small lower-case alphabet so matches are common
      style = (phase == 0) ? 1 : ((phase == 1) ? 0 : $urandom_range(5));
      if (style == 1 && phase != 0) begin
        style = 2;
      end
      fold_on = (phase == 0) ? 1'b0 : 1'($urandom_range(1));

      lo = {$urandom, $urandom};
      hi = {$urandom, $urandom};
      for (i = 0; i < MAX_NEEDLE; i++) begin
        if (style == 1) begin
          b = 8'hFF;
        end else if (style == 0) begin
          b = 8'($urandom_range(255));
        end else begin
          b = 8'h61 + 8'($urandom_range(3));
        end
        needle_b[i] = b;
        if (i < 8) begin
          lo[8 * i +: 8] = b;
        end else begin
          hi[8 * (i - 8) +: 8] = b;
        end
      end
      write_reg(REG_NEEDLE_LOW, lo);
      write_reg(REG_NEEDLE_HIGH, hi);
      word = {$urandom, $urandom};
      word[RAW_LEN_BITS-1:0] = len_raw;
      write_reg(REG_NEEDLE_LEN, word);
      word = {$urandom, $urandom};
      word[0] = fold_on;
      write_reg(REG_CASE_FOLD, word);
      if ($urandom_range(3) == 0) begin
        write_reg(REG_UNUSED, {$urandom, $urandom});
      end
      settings_used++;

      no_gaps = (phase == 6) || (phase == 7);

      // Back-pressure: receiver holds off while one-byte haystacks keep coming
      if (phase == 3) begin
        hold_req <= ~hold_req;
        for (k = 0; k < 20; k++) begin
          push_byte(8'($urandom_range(255)), 1'b1, 1'b0, typed_rep);
        end
      end

      nstacks = $urandom_range(2, 5);
      repeat (nstacks) begin
        hay_len = $urandom_range(1, 12);
        if ($urandom_range(9) == 0) begin
          hay_len = $urandom_range(16, 40);
        end
        embed = ($urandom_range(9) < 7);
        if (embed && hay_len < eff) begin
          hay_len = eff + $urandom_range(0, 4);
        end
        pos = embed ? $urandom_range(0, hay_len - eff) : 0;
        for (k = 0; k < hay_len; k++) begin
          if (embed && k >= pos && k < pos + eff) begin
            b = needle_b[k - pos];
            if (fold_on && b >= 8'h61 && b <= 8'h7A && $urandom_range(1) == 1) begin
              b = b - 8'd32;
            end
          end else if (style == 0 || $urandom_range(15) == 0) begin
            b = 8'($urandom_range(255));
          end else if (style == 1) begin
            b = ($urandom_range(1) == 1) ? 8'hFF : 8'($urandom_range(255));
          end else begin
            b = 8'h61 + 8'($urandom_range(3));
            if (fold_on && $urandom_range(1) == 1) begin
              b = b - 8'd32;
            end
          end
          push_byte(b, (k == hay_len - 1), 1'b0, typed_rep);
        end
      end
      phase++;
    end
    no_gaps = 1'b0;

    // Drain and finish
    in_valid_i <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (2 * SETTLE_CYCLES) @(posedge clk_i);
    $display("tb_top: %0d bytes in %0d haystacks, %0d results checked, %0d register settings",
             bytes_sent, stacks_sent, reports_checked, settings_used);
    $display("tb_top: needle lengths 0, 1, 16, 17, 31 and random, case fold on and off");
    if (mismatches == 0 && expected_reports.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
